// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg - shared types and constants for the frame deframer
// Parser phases, result kinds, the result word and configuration codes.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SUM_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] MAGIC_FIRST_RST  = 8'h55;
	localparam logic [BYTE_W-1:0] MAGIC_SECOND_RST = 8'hAA;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd1;

	typedef enum logic [2:0] {
		PH_MAGIC1  = 3'd0,
		PH_MAGIC2  = 3'd1,
		PH_CMD     = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHK_LO  = 3'd5,
		PH_CHK_HI  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_offset;
		logic [BYTE_W-1:0] frame_command;
		logic [BYTE_W-1:0] frame_length;
	} res_t;

endpackage

// ===== rtl/serial_frame_deframer_sum16_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_deframer_sum16_top - serial frame deframer, 16-bit sum check
// Input register, phase machine and result register for framed byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per
//   word. Frames are magic_first, magic_second, command, length, payload,
//   sum low, sum high; the sum is the 16-bit wrapping sum of command, length
//   and payload.
//   Output channel (out_valid/out_ready) carries one word per payload byte
//   (kind 0, with byte and offset) and one verdict word after the sum high
//   byte (kind 1 accepted, kind 2 mismatch), each with command and length.
//   Sync bytes, command, length and sum low byte produce no output word.
//   Config port: cfg_we writes cfg_wdata into register cfg_index
//   (0 magic_first, 1 magic_second); other indexes are ignored. Write only
//   while no frame byte is in flight.
//   A byte accepted into the input register moves into the result register
//   once that register has room, and its word then shows on out_valid.
//   One byte per cycle while no word waits at a stalled output.
//   Reset: parser hunts the first magic byte, magics return to 0x55/0xAA,
//   both stages empty.
//   Stall: while out_ready is low and a word waits, the input register holds
//   and in_ready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module serial_frame_deframer_sum16_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [sfd_pkg::BYTE_W-1:0]    payload_byte,
	output logic [sfd_pkg::BYTE_W-1:0]    payload_offset,
	output logic [sfd_pkg::BYTE_W-1:0]    frame_command,
	output logic [sfd_pkg::BYTE_W-1:0]    frame_length
);
	import sfd_pkg::*;

	logic [BYTE_W-1:0] magic_first_q;
	logic [BYTE_W-1:0] magic_second_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	logic step;
	logic res_valid;
	res_t res;
	logic space;
	res_t res_out;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= MAGIC_FIRST_RST;
			magic_second_q <= MAGIC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC_FIRST:  magic_first_q  <= cfg_wdata;
				CFG_MAGIC_SECOND: magic_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// s1 byte moves on whenever the result register has room
	assign step     = valid_s1 && space;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte_s1   (rx_byte_s1),
		.magic_first  (magic_first_q),
		.magic_second (magic_second_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	sfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res_in    (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.space     (space),
		.res_out   (res_out)
	);

	assign kind           = res_out.kind;
	assign payload_byte   = res_out.payload_byte;
	assign payload_offset = res_out.payload_offset;
	assign frame_command  = res_out.frame_command;
	assign frame_length   = res_out.frame_length;

	// an empty input register always takes a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty register");

	// a held byte never advances while a word is blocked at the output
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !step)
		else $error("byte advanced into a full result register");

	// a result word loaded means the output shows valid next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> out_valid)
		else $error("result word lost");

endmodule

// ===== rtl/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser - frame phase machine and checksum datapath
// Consumes one registered byte per step and forms at most one result word.
// ----------------------------------------------------------------------------
module sfd_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [sfd_pkg::BYTE_W-1:0] rx_byte_s1,
	input  logic [sfd_pkg::BYTE_W-1:0] magic_first,
	input  logic [sfd_pkg::BYTE_W-1:0] magic_second,
	output logic                    res_valid,
	output sfd_pkg::res_t           res
);
	import sfd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  command_q;
	logic [BYTE_W-1:0]  length_q;
	logic [BYTE_W-1:0]  offset_q;
	logic [BYTE_W-1:0]  check_low_q;
	logic [SUM_W-1:0]   sum_q;
	logic [BYTE_W-1:0]  offset_inc;
	logic [SUM_W-1:0]   sum_add;
	logic               sum_ok;

	assign offset_inc = offset_q + 8'd1;
	assign sum_add    = sum_q + {{(SUM_W-BYTE_W){1'b0}}, rx_byte_s1};
	assign sum_ok     = (sum_q[BYTE_W-1:0] == check_low_q) &&
	                    (sum_q[SUM_W-1:BYTE_W] == rx_byte_s1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_MAGIC1: begin
				if (rx_byte_s1 == magic_first) phase_d = PH_MAGIC2;
			end
			PH_MAGIC2: begin
				// non-matching bytes are skipped, hunt continues
				if (rx_byte_s1 == magic_second) phase_d = PH_CMD;
			end
			PH_CMD:     phase_d = PH_LEN;
			PH_LEN: begin
				phase_d = (rx_byte_s1 != '0) ? PH_PAYLOAD : PH_CHK_LO;
			end
			PH_PAYLOAD: begin
				if (offset_inc >= length_q) phase_d = PH_CHK_LO;
			end
			PH_CHK_LO:  phase_d = PH_CHK_HI;
			PH_CHK_HI:  phase_d = PH_MAGIC1;
			default:    phase_d = PH_MAGIC1;
		endcase
	end

	// result word
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = '0;
		res.payload_offset = '0;
		res.frame_command  = command_q;
		res.frame_length   = length_q;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.payload_byte   = rx_byte_s1;
				res.payload_offset = offset_q;
			end
			PH_CHK_HI: begin
				res_valid = 1'b1;
				res.kind  = sum_ok ? KIND_GOOD : KIND_BAD;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC1;
			command_q   <= '0;
			length_q    <= '0;
			offset_q    <= '0;
			check_low_q <= '0;
			sum_q       <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_CMD: begin
					command_q <= rx_byte_s1;
					sum_q     <= {{(SUM_W-BYTE_W){1'b0}}, rx_byte_s1};
				end
				PH_LEN: begin
					length_q <= rx_byte_s1;
					sum_q    <= sum_add;
					if (rx_byte_s1 != '0) offset_q <= '0;
				end
				PH_PAYLOAD: begin
					sum_q    <= sum_add;
					offset_q <= offset_inc;
				end
				PH_CHK_LO: check_low_q <= rx_byte_s1;
				default: ;
			endcase
		end
	end

	// payload offsets always fall inside the declared length
	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_PAYLOAD |-> res.payload_offset < length_q)
		else $error("payload offset beyond frame length");

	// a verdict comes only from the checksum high byte
	a_verdict_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != KIND_PAYLOAD |-> phase_q == PH_CHK_HI)
		else $error("frame verdict outside checksum phase");

	// zero length jumps straight to the checksum bytes
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && rx_byte_s1 == '0 |=> phase_q == PH_CHK_LO)
		else $error("zero-length frame did not skip payload");

endmodule

// ===== rtl/sfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfd_out_stage - result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sfd_pkg::res_t res_in,
	input  logic          out_ready,
	output logic          out_valid,
	output logic          space,
	output sfd_pkg::res_t res_out
);
	import sfd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for serial_frame_deframer_sum16_top
// Feeds framed byte streams (clean, corrupted, resynced, truncated, noise)
// under several sync-byte settings with random gaps on both channels.
// A local parser model predicts every output word and a scoreboard checks
// each word field by field, oldest first.
// ----------------------------------------------------------------------------
module tb;
	import sfd_pkg::*;

	// spare config indexes, the block must ignore writes to them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// ways a generated frame may be spoiled
	localparam int FLAW_NONE = 0;
	localparam int FLAW_LO   = 1;	// wrong sum low byte
	localparam int FLAW_HI   = 2;	// wrong sum high byte
	localparam int FLAW_SYNC = 3;	// stray bytes between the two sync bytes

	localparam int RANDOM_BYTES = 24;	// frame bytes per config setting
	localparam int PRINT_CAP    = 60;

	// ------------------------------------------------------------------
	// Scoreboard: parser model plus queue of words still due
	// ------------------------------------------------------------------
	class deframe_scoreboard;
		res_t              due_words[$];
		int                errors;
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		phase_t            ph;
		logic [BYTE_W-1:0] cmd_q;
		logic [BYTE_W-1:0] len_q;
		logic [BYTE_W-1:0] off_q;
		logic [SUM_W-1:0]  sum_q;
		logic [BYTE_W-1:0] chk_lo_q;

		function new();
			errors      = 0;
			sync_first  = MAGIC_FIRST_RST;
			sync_second = MAGIC_SECOND_RST;
			ph          = PH_MAGIC1;
			cmd_q       = '0;
			len_q       = '0;
			off_q       = '0;
			sum_q       = '0;
			chk_lo_q    = '0;
		endfunction

		function void set_sync(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
			if (idx == CFG_MAGIC_FIRST)
				sync_first = v;
			else if (idx == CFG_MAGIC_SECOND)
				sync_second = v;
		endfunction

		function bit pending();
			return due_words.size() != 0;
		endfunction

		// advance the parser by one accepted byte, queue any word it yields
		function void note_byte(logic [BYTE_W-1:0] b);
			res_t w;
			w = '0;
			case (ph)
				PH_MAGIC1: begin
					if (b == sync_first)
						ph = PH_MAGIC2;
				end
				PH_MAGIC2: begin
					// anything but the second sync byte is skipped, hunt goes on
					if (b == sync_second)
						ph = PH_CMD;
				end
				PH_CMD: begin
					cmd_q = b;
					sum_q = SUM_W'(b);
					ph    = PH_LEN;
				end
				PH_LEN: begin
					len_q = b;
					sum_q = sum_q + SUM_W'(b);
					if (b != 0) begin
						off_q = '0;
						ph    = PH_PAYLOAD;
					end else begin
						ph = PH_CHK_LO;
					end
				end
				PH_PAYLOAD: begin
					w.kind           = KIND_PAYLOAD;
					w.payload_byte   = b;
					w.payload_offset = off_q;
					w.frame_command  = cmd_q;
					w.frame_length   = len_q;
					due_words.push_back(w);
					sum_q = sum_q + SUM_W'(b);
					off_q = off_q + 1'b1;
					if (off_q >= len_q)
						ph = PH_CHK_LO;
				end
				PH_CHK_LO: begin
					chk_lo_q = b;
					ph       = PH_CHK_HI;
				end
				PH_CHK_HI: begin
					ph = PH_MAGIC1;
					w.kind = (sum_q[7:0] == chk_lo_q && sum_q[15:8] == b) ?
						KIND_GOOD : KIND_BAD;
					w.frame_command = cmd_q;
					w.frame_length  = len_q;
					due_words.push_back(w);
				end
				default: ph = PH_MAGIC1;
			endcase
		endfunction

		task report(string what);
			if (errors < PRINT_CAP)
				$display("tb: mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_word(logic [1:0] k, logic [BYTE_W-1:0] pb, logic [BYTE_W-1:0] po,
				logic [BYTE_W-1:0] fc, logic [BYTE_W-1:0] fl);
			res_t e;
			if (due_words.size() == 0) begin
				report($sformatf("unexpected word kind=%0d byte=%h", k, pb));
				return;
			end
			e = due_words.pop_front();
			if (k !== e.kind)
				report($sformatf("kind %0d, want %0d", k, e.kind));
			if (pb !== e.payload_byte)
				report($sformatf("payload_byte %h, want %h", pb, e.payload_byte));
			if (po !== e.payload_offset)
				report($sformatf("payload_offset %0d, want %0d", po, e.payload_offset));
			if (fc !== e.frame_command)
				report($sformatf("frame_command %h, want %h", fc, e.frame_command));
			if (fl !== e.frame_length)
				report($sformatf("frame_length %0d, want %0d", fl, e.frame_length));
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT signals, the driven inputs known from time zero
	// ------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           kind;
	logic [BYTE_W-1:0]    payload_byte;
	logic [BYTE_W-1:0]    payload_offset;
	logic [BYTE_W-1:0]    frame_command;
	logic [BYTE_W-1:0]    frame_length;

	deframe_scoreboard sb = new();

	// current sync bytes, used to build frames
	logic [BYTE_W-1:0] sync_a = MAGIC_FIRST_RST;
	logic [BYTE_W-1:0] sync_b = MAGIC_SECOND_RST;

	bit send_calm;		// no gaps on the input side for this frame
	int frame_bytes;	// bytes sent as part of frames, drives phase length

	always #2 clk = ~clk;

	serial_frame_deframer_sum16_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.payload_offset (payload_offset),
		.frame_command  (frame_command),
		.frame_length   (frame_length)
	);

	// ------------------------------------------------------------------
	// Output side: every word accepted at an edge is checked with the
	// values seen before that edge's updates.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(kind, payload_byte, payload_offset, frame_command,
				frame_length);
	end

	// Receiver stalls: out_ready may drop for a random gap before each word,
	// with a calm stretch of 16 words out of every 64 where it never stalls.
	initial begin
		int w;
		int nword;
		nword = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			w = ((nword % 64) < 16) ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				if (out_ready)
					out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			if (!out_ready)
				out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			nword++;
		end
	end

	// ------------------------------------------------------------------
	// Input side tasks
	// ------------------------------------------------------------------

	// One byte: optional gap, then hold valid until the block takes it.
	// valid is only dropped when a gap follows, so back-to-back bytes
	// never see valid lowered and raised in the same step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	// Full frame with the current sync bytes; sum computed here, then
	// optionally spoiled.
	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input int len,
			input int flaw);
		logic [SUM_W-1:0]  s;
		logic [BYTE_W-1:0] p;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		int                n;
		send_byte(sync_a);
		if (flaw == FLAW_SYNC) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				p = BYTE_W'($urandom);
				if (p == sync_b)
					p = ~p;
				send_byte(p);
			end
		end
		send_byte(sync_b);
		send_byte(cmd);
		send_byte(BYTE_W'(len));
		s = SUM_W'(cmd) + SUM_W'(BYTE_W'(len));
		for (int i = 0; i < len; i++) begin
			p = BYTE_W'($urandom);
			s = s + SUM_W'(p);
			send_byte(p);
		end
		lo = s[7:0];
		hi = s[15:8];
		if (flaw == FLAW_LO)
			lo = lo ^ BYTE_W'($urandom_range(1, 255));
		if (flaw == FLAW_HI)
			hi = hi ^ BYTE_W'($urandom_range(1, 255));
		send_byte(lo);
		send_byte(hi);
		frame_bytes += 6 + len;
	endtask

	// Stop sending and wait until every predicted word has come out,
	// then let the bytes that yield no word (sync, cmd, len, sum lo) pass.
	task automatic settle();
		if (in_valid)
			in_valid <= 1'b0;
		while (sb.pending())
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// config write, only called after settle()
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_sync(idx, v);
		if (idx == CFG_MAGIC_FIRST)
			sync_a = v;
		else if (idx == CFG_MAGIC_SECOND)
			sync_b = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed frames with random content; some noise bursts
	// and truncated frames that knock the parser out of step.
	task automatic run_frames(input int quota);
		int               start;
		int               r;
		int               len;
		int               n;
		logic [BYTE_W-1:0] cmd;
		start = frame_bytes;
		while (frame_bytes - start < quota) begin
			send_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			cmd = BYTE_W'($urandom);
			if (r < 6) begin
				n = $urandom_range(1, 5);
				repeat (n) send_byte(BYTE_W'($urandom));
			end else if (r < 9) begin
				// frame cut off before its payload ends
				len = $urandom_range(2, 8);
				send_byte(sync_a);
				send_byte(sync_b);
				send_byte(cmd);
				send_byte(BYTE_W'(len));
				n = $urandom_range(0, len - 1);
				repeat (n) send_byte(BYTE_W'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					len = 0;
				else if (r < 85)
					len = $urandom_range(1, 8);
				else if (r < 97)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(41, 254);
				r = $urandom_range(0, 9);
				send_frame(cmd, len, (r == 0) ? FLAW_LO : (r == 1) ? FLAW_HI :
					(r == 2) ? FLAW_SYNC : FLAW_NONE);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int k;
		send_calm   = 1'b0;
		frame_bytes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset sync bytes
		send_byte(8'h00);		// hunt ignores non-sync bytes
		send_byte(8'hFF);
		send_frame(8'h00, 0, FLAW_NONE);	// zero length, sum bytes follow length
		// second sync mismatch: stray bytes skipped, hunt for second sync goes on
		send_byte(sync_a);
		send_byte(8'h13);
		send_byte(sync_a);
		send_byte(sync_b);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'hFF);	// sum 0x01FF, low byte first
		send_byte(8'h01);
		send_frame(8'h5A, 2, FLAW_LO);	// checksum mismatch

		// random, reset sync bytes, one frame at the longest length
		send_calm = 1'b1;
		send_frame(BYTE_W'($urandom), 255, FLAW_NONE);
		run_frames(RANDOM_BYTES / 2);
		settle();	// sender holds off until every word is out
		run_frames(RANDOM_BYTES / 2);

		// writes to unused indexes must not touch the sync bytes
		settle();
		set_reg(CFG_SPARE_A, 8'hFF);
		set_reg(CFG_SPARE_B, 8'h00);
		set_reg(CFG_MAGIC_FIRST, 8'h00);
		set_reg(CFG_MAGIC_SECOND, 8'hFF);
		run_frames(RANDOM_BYTES);

		settle();
		set_reg(CFG_MAGIC_FIRST, 8'hFF);
		set_reg(CFG_MAGIC_SECOND, 8'h00);
		run_frames(RANDOM_BYTES);

		// same byte for both syncs
		settle();
		set_reg(CFG_MAGIC_FIRST, 8'h7E);
		set_reg(CFG_MAGIC_SECOND, 8'h7E);
		run_frames(RANDOM_BYTES);

		settle();
		set_reg(CFG_MAGIC_FIRST, BYTE_W'($urandom));
		set_reg(CFG_MAGIC_SECOND, BYTE_W'($urandom));
		run_frames(RANDOM_BYTES);

		// drain with a bound, then a short tail to catch stray words
		if (in_valid)
			in_valid <= 1'b0;
		k = 0;
		while (sb.pending() && k < 2000) begin
			@(posedge clk);
			k++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending())
			sb.report($sformatf("%0d expected words never came", sb.due_words.size()));
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#400000;
		$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/sfd_out_stage.sv
rtl/serial_frame_deframer_sum16_top.sv
tb/tb.sv
